// ----- rtl/frra_pkg.sv -----
// Shared constants, codes and helpers for the fenced ring region allocator.
package frra_pkg;

	localparam int REGION_SLOTS = 256;
	localparam int OFFSET_BITS  = 24;
	localparam int SLOT_W       = $clog2(REGION_SLOTS);
	localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
	localparam int SIZE_W       = OFFSET_BITS + 1;
	localparam int CMD_W        = 2;
	localparam int STATUS_W     = 2;

	localparam logic [SIZE_W-1:0] CAP_MAX   = SIZE_W'(1) << OFFSET_BITS;
	localparam logic [SIZE_W-1:0] RING_RST  = SIZE_W'(65536);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(REGION_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(REGION_SLOTS - 1);

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WAIT_FAIL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_REGION = 2'd3;

	localparam logic [0:0] REG_RING_BYTES = 1'b0;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
		return (i == SLOT_LAST) ? '0 : i + SLOT_W'(1);
	endfunction

endpackage

// ----- rtl/fenced_ring_region_allocator.sv -----
// Fenced ring region allocator: sequencer, region store and register port.
// Retire, query and rejected requests go from decode to done and the result beat; push and
// append go through check, position, commit and done, retiring regions in check, or go to
// done on a failed wait (one wait per cycle, paced by the registered read of oldest begin).
// One item in work at a time; the next is accepted while the last result waits to drain.
// Reset clears offsets, indexes and counts and sets ring_bytes to 65536; store not cleared.
module fenced_ring_region_allocator
	import frra_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CMD_W-1:0]       cmd,
	input  logic [SIZE_W-1:0]      req_size,
	input  logic                   wait_ok,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [STATUS_W-1:0]    status,
	output logic [CNT_W-1:0]       retired_count,
	output logic [OFFSET_BITS-1:0] region_begin,
	output logic [OFFSET_BITS-1:0] region_end,
	output logic [CNT_W-1:0]       live_regions
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_POS    = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]             state_q;
	logic [SIZE_W-1:0]      ring_q;
	logic [OFFSET_BITS-1:0] wo_q;
	logic [SLOT_W-1:0]      newest_q, oldest_q;
	logic [CNT_W-1:0]       live_q, retired_q;
	logic [OFFSET_BITS-1:0] nb_q, ne_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [SIZE_W-1:0]      size_q;
	logic                   ok_q;
	logic [STATUS_W-1:0]    st_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [SIZE_W-1:0]      left_q;

	logic [OFFSET_BITS-1:0] begin_mem [REGION_SLOTS];
	logic [OFFSET_BITS-1:0] rd_q;

	logic [SIZE_W-1:0]      cap;
	logic [SIZE_W-1:0]      b_ext, e_ext, free_span;
	logic                   fits;
	logic                   retire_now;
	logic [SLOT_W-1:0]      rd_addr;
	logic [SLOT_W-1:0]      push_slot;
	logic [OFFSET_BITS-1:0] npos;
	logic                   cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_RING_BYTES);
	assign prdata   = (paddr[2] == REG_RING_BYTES) ? {{(32 - SIZE_W){1'b0}}, ring_q} : '0;
	assign in_ready = (state_q == S_IDLE);

	assign cap = (ring_q > CAP_MAX) ? CAP_MAX : ring_q;

	// free span from newest end round to oldest begin
	assign b_ext = {1'b0, rd_q};
	assign e_ext = {1'b0, ne_q};
	always_comb begin
		if (e_ext < b_ext)
			free_span = b_ext - e_ext;
		else if (e_ext >= cap)
			free_span = b_ext;
		else
			free_span = cap - (e_ext - b_ext);
	end

	assign fits = (live_q != CNT_FULL) &&
		((live_q == '0) || ((ne_q != rd_q) && (free_span >= size_q)));

	assign retire_now = (state_q == S_CHECK) && !fits && (live_q != '0);
	assign rd_addr    = retire_now ? next_slot(oldest_q) : oldest_q;
	assign push_slot  = next_slot(newest_q);

	// advance: size equal to the space left wraps to zero
	assign npos = (size_q < left_q) ? OFFSET_BITS'(SIZE_W'(pos_q) + size_q)
		: OFFSET_BITS'(size_q - left_q);

	always_ff @(posedge clk) begin
		if (state_q == S_COMMIT && cmd_q == CMD_PUSH)
			begin_mem[push_slot] <= pos_q;
		rd_q <= begin_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= RING_RST;
		end else if (cfg_wr) begin
			ring_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			size_q <= req_size;
			ok_q   <= wait_ok;
		end
		if (state_q == S_POS) begin
			pos_q  <= (SIZE_W'(wo_q) >= cap) ? '0 : wo_q;
			left_q <= cap - ((SIZE_W'(wo_q) >= cap) ? '0 : SIZE_W'(wo_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wo_q          <= '0;
			newest_q      <= '0;
			oldest_q      <= '0;
			live_q        <= '0;
			retired_q     <= '0;
			nb_q          <= '0;
			ne_q          <= '0;
			st_q          <= ST_OK;
			out_valid     <= 1'b0;
			status        <= ST_OK;
			retired_count <= '0;
			region_begin  <= '0;
			region_end    <= '0;
			live_regions  <= '0;
		end else begin
			if (out_valid && out_ready && state_q != S_DONE)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						retired_q <= '0;
						st_q      <= ST_OK;
						state_q   <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (cmd_q)
						CMD_PUSH, CMD_APPEND: begin
							if (cmd_q == CMD_APPEND && live_q == '0) begin
								st_q    <= ST_NO_REGION;
								state_q <= S_DONE;
							end else if (size_q > cap) begin
								st_q    <= ST_TOO_BIG;
								state_q <= S_DONE;
							end else begin
								state_q <= S_CHECK;
							end
						end
						CMD_RETIRE: begin
							if (live_q == '0) begin
								st_q <= ST_NO_REGION;
							end else begin
								oldest_q  <= next_slot(oldest_q);
								live_q    <= live_q - CNT_W'(1);
								retired_q <= CNT_W'(1);
								st_q      <= ok_q ? ST_OK : ST_WAIT_FAIL;
							end
							state_q <= S_DONE;
						end
						CMD_QUERY: begin
							st_q    <= (live_q == '0) ? ST_NO_REGION : ST_OK;
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_CHECK: begin
					// one fence wait per cycle until the request fits, a wait fails or no region is left
					if (fits) begin
						state_q <= S_POS;
					end else if (live_q == '0) begin
						st_q    <= ST_WAIT_FAIL;
						state_q <= S_DONE;
					end else begin
						oldest_q  <= next_slot(oldest_q);
						live_q    <= live_q - CNT_W'(1);
						retired_q <= retired_q + CNT_W'(1);
						if (!ok_q) begin
							st_q    <= ST_WAIT_FAIL;
							state_q <= S_DONE;
						end
					end
				end
				S_POS: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					wo_q <= npos;
					ne_q <= npos;
					if (cmd_q == CMD_PUSH) begin
						newest_q <= push_slot;
						nb_q     <= pos_q;
						if (live_q == '0)
							oldest_q <= push_slot;
						live_q <= live_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						status        <= st_q;
						retired_count <= retired_q;
						region_begin  <= (live_q != '0) ? nb_q : '0;
						region_end    <= (live_q != '0) ? ne_q : '0;
						live_regions  <= live_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the fenced ring region allocator: directed table, random phases.
module testbench;
	import frra_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]    st;
		logic [CNT_W-1:0]       retired;
		logic [OFFSET_BITS-1:0] rbegin;
		logic [OFFSET_BITS-1:0] rend;
		logic [CNT_W-1:0]       live;
	} alloc_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SIZE_W-1:0] size;
		logic              ok;
		logic              typed;
		alloc_result_t     want;
	} alloc_row_t;

	typedef struct packed {
		logic [SIZE_W-1:0] ring;
		int                items;
		int                push_pct;
		int                small_pct;
		int                small_max;
		bit                quiet;
		bit                hold;
	} ring_phase_t;

	localparam logic [2:0] RING_ADDR = {REG_RING_BYTES, 2'b00};
	localparam int DIR_ROWS = 20;
	localparam int PHASES = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [2:0]             paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_ready;
	logic [CMD_W-1:0]       cmd;
	logic [SIZE_W-1:0]      req_size;
	logic                   wait_ok;
	logic                   out_valid;
	logic                   out_ready;
	logic [STATUS_W-1:0]    status;
	logic [CNT_W-1:0]       retired_count;
	logic [OFFSET_BITS-1:0] region_begin;
	logic [OFFSET_BITS-1:0] region_end;
	logic [CNT_W-1:0]       live_regions;

	// shadow state of the allocator
	logic [SIZE_W-1:0]      ring_cfg;
	logic [OFFSET_BITS-1:0] wr_ofs;
	logic [OFFSET_BITS-1:0] rgn_begin [REGION_SLOTS];
	logic [OFFSET_BITS-1:0] rgn_end [REGION_SLOTS];
	logic [SLOT_W-1:0]      newest_slot;
	logic [SLOT_W-1:0]      oldest_slot;
	int                     live_cnt;

	alloc_result_t expected_beats [$];
	int fail_cnt;
	bit quiet;
	bit hold_req;

	alloc_row_t directed_rows [DIR_ROWS] = '{
		'{CMD_QUERY,  25'd0,        1'b1, 1'b1, '{ST_NO_REGION, 9'd0, 24'd0, 24'd0, 9'd0}},
		'{CMD_RETIRE, 25'd0,        1'b1, 1'b1, '{ST_NO_REGION, 9'd0, 24'd0, 24'd0, 9'd0}},
		'{CMD_APPEND, 25'd5,        1'b1, 1'b1, '{ST_NO_REGION, 9'd0, 24'd0, 24'd0, 9'd0}},
		'{CMD_PUSH,   25'h1FFFFFF,  1'b1, 1'b1, '{ST_TOO_BIG,   9'd0, 24'd0, 24'd0, 9'd0}},
		'{CMD_PUSH,   25'd65537,    1'b0, 1'b1, '{ST_TOO_BIG,   9'd0, 24'd0, 24'd0, 9'd0}},
		'{CMD_PUSH,   25'd0,        1'b1, 1'b1, '{ST_OK,        9'd0, 24'd0, 24'd0, 9'd1}},
		'{CMD_PUSH,   25'd100,      1'b1, 1'b0, '0},
		'{CMD_APPEND, 25'd50,       1'b1, 1'b0, '0},
		'{CMD_PUSH,   25'd65536,    1'b0, 1'b0, '0},
		'{CMD_QUERY,  25'd0,        1'b0, 1'b0, '0},
		'{CMD_PUSH,   25'd65536,    1'b1, 1'b0, '0},
		'{CMD_APPEND, 25'd0,        1'b1, 1'b0, '0},
		'{CMD_PUSH,   25'd1000,     1'b1, 1'b0, '0},
		'{CMD_PUSH,   25'd2000,     1'b1, 1'b0, '0},
		'{CMD_APPEND, 25'd500,      1'b1, 1'b0, '0},
		'{CMD_PUSH,   25'h1000000,  1'b1, 1'b0, '0},
		'{CMD_RETIRE, 25'd0,        1'b0, 1'b0, '0},
		'{CMD_QUERY,  25'd0,        1'b1, 1'b0, '0},
		'{CMD_RETIRE, 25'd0,        1'b1, 1'b0, '0},
		'{CMD_QUERY,  25'd0,        1'b1, 1'b1, '{ST_NO_REGION, 9'd0, 24'd0, 24'd0, 9'd0}}
	};

	ring_phase_t ring_phases [PHASES] = '{
		'{25'd65536,    200, 45,  60, 4096,    1'b0, 1'b0},
		'{25'h1000000,  420, 90, 100, 64,      1'b0, 1'b1},
		'{25'd64,       150, 45,  60, 16,      1'b0, 1'b0},
		'{25'd1,         80, 45,  60, 1,       1'b1, 1'b0},
		'{25'd0,         40, 45,  60, 0,       1'b0, 1'b0},
		'{25'h1FFFFFF,  150, 50,  60, 1 << 20, 1'b1, 1'b0},
		'{25'd300,      150, 50,  60, 40,      1'b0, 1'b0},
		'{25'd65536,    100, 45,  60, 4096,    1'b0, 1'b0}
	};

	fenced_ring_region_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.req_size      (req_size),
		.wait_ok       (wait_ok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.retired_count (retired_count),
		.region_begin  (region_begin),
		.region_end    (region_end),
		.live_regions  (live_regions)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#30000000;
		$display("fenced_ring_region_allocator verification failed");
		$finish;
	end

	function automatic longint unsigned ring_cap();
		return (ring_cfg > CAP_MAX) ? longint'(CAP_MAX) : longint'(ring_cfg);
	endfunction

	// Advances the shadow state by one command and returns the result beat it causes.
	function automatic alloc_result_t alloc_predict(input logic [CMD_W-1:0] c,
			input logic [SIZE_W-1:0] sz, input logic ok);
		alloc_result_t r;
		longint unsigned cap, size, pos, npos, left, b, e, tail;
		bit fits, stop;
		r = '0;
		cap = ring_cap();
		size = sz;
		r.st = ST_OK;
		if (c == CMD_PUSH || c == CMD_APPEND) begin
			if (c == CMD_APPEND && live_cnt == 0) begin
				r.st = ST_NO_REGION;
			end else if (size > cap) begin
				r.st = ST_TOO_BIG;
			end else begin
				stop = 1'b0;
				while (!stop) begin
					if (live_cnt >= REGION_SLOTS) begin
						fits = 1'b0;
					end else if (live_cnt == 0) begin
						fits = 1'b1;
					end else begin
						b = rgn_begin[oldest_slot];
						e = rgn_end[newest_slot];
						// newest end on oldest begin means no room at all
						if (e == b) begin
							fits = 1'b0;
						end else if (e < b) begin
							fits = (b - e >= size);
						end else begin
							tail = (e >= cap) ? 0 : cap - e;
							fits = (tail + b >= size);
						end
					end
					if (fits) begin
						stop = 1'b1;
					end else if (live_cnt == 0) begin
						r.st = ST_WAIT_FAIL;
						stop = 1'b1;
					end else begin
						oldest_slot = oldest_slot + 1'b1;
						live_cnt--;
						r.retired = r.retired + 1'b1;
						if (!ok) begin
							r.st = ST_WAIT_FAIL;
							stop = 1'b1;
						end
					end
				end
				if (r.st == ST_OK) begin
					// stale write offset past a shrunk ring restarts at 0
					pos = (wr_ofs >= cap) ? 0 : wr_ofs;
					left = cap - pos;
					if (size <= left) begin
						npos = pos + size;
						if (npos >= cap) npos = npos - cap;
					end else begin
						npos = size - left;
					end
					wr_ofs = npos[OFFSET_BITS-1:0];
					if (c == CMD_PUSH) begin
						newest_slot = newest_slot + 1'b1;
						rgn_begin[newest_slot] = pos[OFFSET_BITS-1:0];
						rgn_end[newest_slot] = npos[OFFSET_BITS-1:0];
						if (live_cnt == 0) oldest_slot = newest_slot;
						live_cnt++;
					end else begin
						rgn_end[newest_slot] = npos[OFFSET_BITS-1:0];
					end
				end
			end
		end else if (c == CMD_RETIRE) begin
			if (live_cnt == 0) begin
				r.st = ST_NO_REGION;
			end else begin
				oldest_slot = oldest_slot + 1'b1;
				live_cnt--;
				r.retired = CNT_W'(1);
				r.st = ok ? ST_OK : ST_WAIT_FAIL;
			end
		end else begin
			r.st = (live_cnt == 0) ? ST_NO_REGION : ST_OK;
		end
		if (live_cnt > 0) begin
			r.rbegin = rgn_begin[newest_slot];
			r.rend = rgn_end[newest_slot];
		end
		r.live = CNT_W'(live_cnt);
		return r;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		alloc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, got status %0d",
					$time, status);
				fail_cnt++;
			end else begin
				want = expected_beats.pop_front();
				check_field("status", want.st, status);
				check_field("retired_count", want.retired, retired_count);
				check_field("region_begin", want.rbegin, region_begin);
				check_field("region_end", want.rend, region_end);
				check_field("live_regions", want.live, live_regions);
			end
		end
	end

	// receiver: random stall per beat, plus one long hold-off on request
	initial begin : result_sink
		int w;
		out_ready = 1'b0;
		forever begin
			w = quiet ? 0 : $urandom_range(0, 14);
			if (hold_req) begin
				hold_req = 1'b0;
				w = w + 400;
			end
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [SIZE_W-1:0] sz,
			input logic ok, input bit typed, input alloc_result_t want);
		int gap;
		alloc_result_t pred;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		req_size <= sz;
		wait_ok <= ok;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = alloc_predict(c, sz, ok);
		expected_beats.push_back(typed ? want : pred);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	// write ring_bytes, then read it back in the following transfer
	task automatic ring_write(input logic [SIZE_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RING_ADDR;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		ring_cfg = val;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== 32'(val)) begin
			$display("%0t: ring_bytes readback mismatch, expected %0d, got %0d",
				$time, val, prdata);
			fail_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		int r, sel, p, n;
		logic [CMD_W-1:0] c;
		logic [SIZE_W-1:0] sz;
		longint unsigned cap;
		ring_phase_t ph;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cmd = CMD_QUERY;
		req_size = '0;
		wait_ok = 1'b0;
		fail_cnt = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		ring_cfg = RING_RST;
		wr_ofs = '0;
		newest_slot = '0;
		oldest_slot = '0;
		live_cnt = 0;
		for (int i = 0; i < REGION_SLOTS; i++) begin
			rgn_begin[i] = '0;
			rgn_end[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_beat(directed_rows[i].cmd, directed_rows[i].size, directed_rows[i].ok,
				directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		for (p = 0; p < PHASES; p++) begin
			ph = ring_phases[p];
			ring_write(ph.ring);
			@(posedge clk);
			quiet = ph.quiet;
			hold_req = ph.hold;
			for (n = 0; n < ph.items; n++) begin
				cap = ring_cap();
				r = $urandom_range(0, 99);
				if (r < ph.push_pct) begin
					c = CMD_PUSH;
				end else begin
					sel = $urandom_range(0, 19);
					c = (sel < 8) ? CMD_APPEND : (sel < 15) ? CMD_RETIRE : CMD_QUERY;
				end
				if ($urandom_range(0, 99) < ph.small_pct) begin
					sz = SIZE_W'($urandom_range(0, ph.small_max));
				end else begin
					case ($urandom_range(0, 4))
						0: sz = SIZE_W'($urandom_range(0, 32'(cap)));
						1: sz = SIZE_W'($urandom());
						2: sz = SIZE_W'(cap);
						3: sz = SIZE_W'(cap + 1);
						default: sz = '0;
					endcase
				end
				send_beat(c, sz, $urandom_range(0, 9) != 0, 1'b0, '0);
			end
			// a full-ring push after the fill phase retires every live region
			if (ph.hold)
				send_beat(CMD_PUSH, SIZE_W'(ring_cap()), 1'b1, 1'b0, '0);
			drain_results();
		end
		quiet = 1'b0;
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("fenced_ring_region_allocator verification clean");
		else
			$display("fenced_ring_region_allocator verification failed");
		$finish;
	end

endmodule
